@@ sv/nmea_pkg.sv @@
package nmea_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [3:0] NIBBLE_MASK = 4'hf;
	localparam logic [7:0] COUNT_MAX = 8'hff;

	localparam logic [7:0] BYTE_LIMIT_RST  = 8'd128;
	localparam logic [7:0] FIELD_LIMIT_RST = 8'd25;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_BYTE_LIMIT  = 1'b0;
	localparam logic REG_FIELD_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_CKSUM    = 2'd2,
		KIND_FRAMING  = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_DATA = 6'b000010,
		PH_CK1  = 6'b000100,
		PH_CK2  = 6'b001000,
		PH_CR   = 6'b010000,
		PH_LF   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_limit;
		logic [7:0] field_limit;
	} cfg_t;

	// Upper-case ASCII hex character for the low nibble of the argument.
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] res;
		if (nib <= 4'd9) begin
			res = CH_ZERO + {4'd0, nib};
		end else begin
			res = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return res;
	endfunction

endpackage

@@ sv/nmea_cfg_regs.sv @@
module nmea_cfg_regs
	import nmea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [7:0] byte_limit_q;
	logic [7:0] field_limit_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Registers are word aligned; only the word select bit decodes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q  <= BYTE_LIMIT_RST;
			field_limit_q <= FIELD_LIMIT_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_BYTE_LIMIT) begin
				byte_limit_q <= pwdata[7:0];
			end else begin
				field_limit_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_FIELD_LIMIT) ? {24'd0, field_limit_q}
	                                              : {24'd0, byte_limit_q};

	assign cfg.byte_limit  = byte_limit_q;
	assign cfg.field_limit = field_limit_q;

endmodule

@@ sv/nmea_framer.sv @@
module nmea_framer
	import nmea_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] rx_byte_s1,
	input  cfg_t       cfg,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] field_index,
	output logic       field_overflow,
	output logic       byte_overflow,
	output logic [7:0] byte_count,
	output logic [7:0] field_count
);

	phase_t     phase_q;
	logic [7:0] xor_q;
	logic [7:0] bytes_q;
	logic [7:0] fields_q;

	phase_t     phase_d;
	logic [7:0] xor_d;
	logic [7:0] bytes_d;
	logic [7:0] fields_d;

	logic       res_vld;
	kind_t      res_kind;
	logic [7:0] res_db;
	logic [7:0] res_fi;
	logic       res_fo;
	logic       res_bo;

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] data_byte_q;
	logic [7:0] field_index_q;
	logic       field_overflow_q;
	logic       byte_overflow_q;
	logic [7:0] byte_count_q;
	logic [7:0] field_count_q;

	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		bytes_d  = bytes_q;
		fields_d = fields_q;
		res_vld  = 1'b0;
		res_kind = KIND_DATA;
		res_db   = 8'd0;
		res_fi   = 8'd0;
		res_fo   = 1'b0;
		res_bo   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte_s1 == CH_DOLLAR) begin
					bytes_d  = 8'd0;
					fields_d = 8'd1;
					xor_d    = 8'd0;
					phase_d  = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rx_byte_s1 == CH_STAR) begin
					phase_d = PH_CK1;
				end else begin
					res_vld = 1'b1;
					xor_d   = xor_q ^ rx_byte_s1;
					res_db  = rx_byte_s1;
					res_fi  = (fields_q != 8'd0) ? fields_q - 8'd1 : 8'd0;
					// A comma closes its field; it is reported as zero.
					if (rx_byte_s1 == CH_COMMA) begin
						res_db = 8'd0;
						if (fields_q != COUNT_MAX) begin
							fields_d = fields_q + 8'd1;
						end
						if (fields_d >= cfg.field_limit) begin
							res_fo  = 1'b1;
							phase_d = PH_IDLE;
						end
					end
					if (bytes_q != COUNT_MAX) begin
						bytes_d = bytes_q + 8'd1;
					end
					if (bytes_d >= cfg.byte_limit) begin
						res_bo  = 1'b1;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_CK1: begin
				if (rx_byte_s1 == hex_digit(xor_q[7:4])) begin
					phase_d = PH_CK2;
				end else begin
					phase_d  = PH_IDLE;
					res_vld  = 1'b1;
					res_kind = KIND_CKSUM;
				end
			end
			PH_CK2: begin
				if (rx_byte_s1 == hex_digit(xor_q[3:0] & NIBBLE_MASK)) begin
					phase_d = PH_CR;
				end else begin
					phase_d  = PH_IDLE;
					res_vld  = 1'b1;
					res_kind = KIND_CKSUM;
				end
			end
			PH_CR: begin
				if (rx_byte_s1 == CH_CR) begin
					phase_d = PH_LF;
				end else begin
					phase_d  = PH_IDLE;
					res_vld  = 1'b1;
					res_kind = KIND_FRAMING;
				end
			end
			PH_LF: begin
				phase_d  = PH_IDLE;
				res_vld  = 1'b1;
				res_kind = (rx_byte_s1 == CH_LF) ? KIND_ACCEPTED : KIND_FRAMING;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xor_q    <= 8'd0;
			bytes_q  <= 8'd0;
			fields_q <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			bytes_q  <= bytes_d;
			fields_q <= fields_d;
		end
	end

	// The result register holds while the downstream side stalls; advance is
	// never high in that situation, so nothing is overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_vld;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			kind_q           <= res_kind;
			data_byte_q      <= res_db;
			field_index_q    <= res_fi;
			field_overflow_q <= res_fo;
			byte_overflow_q  <= res_bo;
			byte_count_q     <= bytes_d;
			field_count_q    <= fields_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_byte_q;
	assign field_index    = field_index_q;
	assign field_overflow = field_overflow_q;
	assign byte_overflow  = byte_overflow_q;
	assign byte_count     = byte_count_q;
	assign field_count    = field_count_q;

endmodule

@@ sv/nmea_sentence_receiver.sv @@
// NMEA sentence receiver: takes one received character per transaction, frames
// sentences that start with '$', reports every data byte with its field index
// (a comma as 0), checks the two upper-case hex checksum digits after '*' and
// then CR and LF, and gives one outcome per sentence unless a limit ends it
// early. Each character is held in an input register; the framing state and
// result are computed and written to the output register when it is free, so
// a new character can be accepted every cycle while in_stall is low. in_stall
// is raised only while an input character waits behind an untaken result.
// Limit registers sit at byte addresses 0 (byte_limit) and 4 (field_limit) and
// must only be written while no transaction is in flight.
module nmea_sentence_receiver
	import nmea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic [7:0]         field_index,
	output logic               field_overflow,
	output logic               byte_overflow,
	output logic [7:0]         byte_count,
	output logic [7:0]         field_count
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_blocked;
	logic       advance;
	logic       in_take;

	assign out_blocked = out_valid & out_stall;
	assign advance     = valid_s1 & ~out_blocked;
	assign in_stall    = valid_s1 & out_blocked;
	assign in_take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	nmea_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nmea_framer u_framer (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.rx_byte_s1     (rx_byte_s1),
		.cfg            (cfg),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.kind           (kind),
		.data_byte      (data_byte),
		.field_index    (field_index),
		.field_overflow (field_overflow),
		.byte_overflow  (byte_overflow),
		.byte_count     (byte_count),
		.field_count    (field_count)
	);

endmodule
